// File: hdl/fatan_pkg.sv
// fatan_pkg: shared constants and the per-beat flag struct for the atan2 pipeline.
// No dependencies.
`default_nettype none
package fatan_pkg;

  localparam int MAG_BITS = 20;
  localparam int PROD_W   = 2 * MAG_BITS;
  localparam int DEN_W    = PROD_W + 5;
  localparam int D2_W     = DEN_W + 1;
  localparam logic [63:0] PI_Q32 = 64'd13493037705;

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_neg;
    logic neg_z;
    logic swap;
  } flags_t;

endpackage
`default_nettype wire

// File: hdl/fatan_front.sv
// fatan_front: magnitudes, operand order, products and the division operands.
// Three register stages; uses fatan_pkg.
`default_nettype none
module fatan_front #(
  parameter int INPUT_WIDTH     = 16,
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int NW              = ANGLE_FRAC_BITS + 47
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [INPUT_WIDTH-1:0]       y_value,
  input  wire logic [INPUT_WIDTH-1:0]       x_value,
  output logic                              out_valid,
  output fatan_pkg::flags_t                 out_flags,
  output logic [NW-1:0]                     num,
  output logic [fatan_pkg::D2_W-1:0]        d2
);
  localparam int MB = fatan_pkg::MAG_BITS;
  localparam int AW = (INPUT_WIDTH > MB) ? INPUT_WIDTH : MB;
  localparam int SW = $clog2(AW + 1);
  localparam int PW = fatan_pkg::PROD_W;

  logic [INPUT_WIDTH-1:0] ay, ax;
  logic [AW-1:0]          a_full, b_full, a_sh, b_sh;
  logic [SW-1:0]          sh;
  fatan_pkg::flags_t      f0;

  logic                   v1, v2;
  fatan_pkg::flags_t      fl1, fl2;
  logic [MB-1:0]          a1, b1;
  logic [PW-1:0]          aa, bb, ab;

  always_comb begin
    ay = y_value[INPUT_WIDTH-1] ? (~y_value + 1'b1) : y_value;
    ax = x_value[INPUT_WIDTH-1] ? (~x_value + 1'b1) : x_value;
    f0.x_zero = (x_value == '0);
    f0.y_zero = (y_value == '0);
    f0.x_neg  = x_value[INPUT_WIDTH-1];
    f0.y_neg  = y_value[INPUT_WIDTH-1];
    f0.neg_z  = x_value[INPUT_WIDTH-1] ^ y_value[INPUT_WIDTH-1];
    f0.swap   = !(ay < ax);
    a_full = f0.swap ? AW'(ay) : AW'(ax);
    b_full = f0.swap ? AW'(ax) : AW'(ay);
    sh = '0;
    for (int k = MB; k < AW; k++) begin
      if (a_full[k]) sh = SW'(k - MB + 1);
    end
    a_sh = a_full >> sh;
    b_sh = b_full >> sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    if (en) begin
      fl1 <= f0;
      a1  <= a_sh[MB-1:0];
      b1  <= b_sh[MB-1:0];
      fl2 <= fl1;
      aa  <= PW'(a1) * PW'(a1);
      bb  <= PW'(b1) * PW'(b1);
      ab  <= PW'(a1) * PW'(b1);
      out_flags <= fl2;
      d2  <= {fatan_pkg::DEN_W'(25) * fatan_pkg::DEN_W'(aa)
              + fatan_pkg::DEN_W'(7) * fatan_pkg::DEN_W'(bb), 1'b0};
      num <= ((NW'(ab) * NW'(50)) << ANGLE_FRAC_BITS)
             + NW'(fatan_pkg::DEN_W'(25) * fatan_pkg::DEN_W'(aa)
                   + fatan_pkg::DEN_W'(7) * fatan_pkg::DEN_W'(bb));
    end
  end
endmodule
`default_nettype wire

// File: hdl/fatan_div_stage.sv
// fatan_div_stage: one restoring-division step, one quotient bit per stage.
// Uses fatan_pkg.
`default_nettype none
module fatan_div_stage #(
  parameter int NW  = 59,
  parameter int QW  = 12,
  parameter int BIT = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire fatan_pkg::flags_t        in_flags,
  input  wire logic [NW-1:0]            in_rem,
  input  wire logic [fatan_pkg::D2_W-1:0] in_d2,
  input  wire logic [QW-1:0]            in_q,
  output logic                          out_valid,
  output fatan_pkg::flags_t             out_flags,
  output logic [NW-1:0]                 out_rem,
  output logic [fatan_pkg::D2_W-1:0]    out_d2,
  output logic [QW-1:0]                 out_q
);
  logic [NW-1:0] dsh;
  logic          take;

  always_comb begin
    dsh  = NW'(in_d2) << BIT;
    take = (in_rem >= dsh);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
    if (en) begin
      out_flags <= in_flags;
      out_d2    <= in_d2;
      out_rem   <= take ? (in_rem - dsh) : in_rem;
      out_q     <= in_q | (QW'(take) << BIT);
    end
  end
endmodule
`default_nettype wire

// File: hdl/fatan_back.sv
// fatan_back: sign, quadrant correction, axis cases and clamp; output register.
// Uses fatan_pkg.
`default_nettype none
module fatan_back #(
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int AWD             = ANGLE_FRAC_BITS + 3,
  parameter logic [AWD-1:0] PI_S      = '0,
  parameter logic [AWD-1:0] HALF_PI_S = '0
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire fatan_pkg::flags_t          in_flags,
  input  wire logic [ANGLE_FRAC_BITS-1:0] in_q,
  output logic                            out_valid,
  output logic [AWD-1:0]                  angle
);
  localparam int RW = AWD + 1;
  logic signed [RW-1:0] s, r, pi_w, hp_w;

  always_comb begin
    pi_w = RW'(PI_S);
    hp_w = RW'(HALF_PI_S);
    s = RW'(in_q);
    if (in_flags.neg_z) s = -s;
    if (in_flags.swap) begin
      r = hp_w - s;
      if (in_flags.y_neg) r = r - pi_w;
    end else begin
      r = s;
      if (in_flags.x_neg) r = in_flags.y_neg ? (r - pi_w) : (r + pi_w);
    end
    if (r > pi_w) r = pi_w;
    if (r < -pi_w) r = -pi_w;
    if (in_flags.x_zero) begin
      if (in_flags.y_zero) r = '0;
      else if (in_flags.y_neg) r = -hp_w;
      else r = hp_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
    if (en) angle <= r[AWD-1:0];
  end
endmodule
`default_nettype wire

// File: hdl/fast_atan2_approximation.sv
// fast_atan2_approximation: four-quadrant atan2 with the 0.28 rational form.
// Uses fatan_pkg, fatan_front, fatan_div_stage, fatan_back.
//
// Input channel: in_valid/in_ready with y_value, x_value (two's complement).
// Output channel: out_valid/out_ready with angle, radians times
// 2^ANGLE_FRAC_BITS, clamped to plus or minus pi.
// One beat in and one beat out per cycle when neither side stalls.
// Pipeline stages in order: three stages form the magnitudes, products
// and division operands, one stage per quotient bit runs the restoring
// divider, one stage applies quadrant corrections and clamp.
// The whole pipeline advances together: in_ready is high when the output
// register is empty or being taken. When the receiver stalls, every stage
// holds, so no beat is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
`default_nettype none
module fast_atan2_approximation #(
  parameter int ANGLE_FRAC_BITS = 12,
  parameter int INPUT_WIDTH     = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [INPUT_WIDTH-1:0]       y_value,
  input  wire logic [INPUT_WIDTH-1:0]       x_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [ANGLE_FRAC_BITS+2:0]        angle
);
  localparam int F   = ANGLE_FRAC_BITS;
  localparam int AWD = F + 3;
  localparam int NW  = F + 47;
  localparam int DW  = fatan_pkg::D2_W;
  localparam logic [63:0] PI_L =
    (fatan_pkg::PI_Q32 + (64'd1 << (31 - F))) >> (32 - F);
  localparam logic [63:0] HP_L =
    (fatan_pkg::PI_Q32 + (64'd1 << (32 - F))) >> (33 - F);
  localparam logic [AWD-1:0] PI_S = PI_L[AWD-1:0];
  localparam logic [AWD-1:0] HALF_PI_S = HP_L[AWD-1:0];

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  logic              v   [F+1];
  fatan_pkg::flags_t fl  [F+1];
  logic [NW-1:0]     rem [F+1];
  logic [DW-1:0]     d2  [F+1];
  logic [F-1:0]      q   [F+1];

  fatan_front #(.INPUT_WIDTH(INPUT_WIDTH), .ANGLE_FRAC_BITS(F), .NW(NW)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .y_value(y_value), .x_value(x_value),
    .out_valid(v[0]), .out_flags(fl[0]), .num(rem[0]), .d2(d2[0])
  );
  assign q[0] = '0;

  for (genvar i = 0; i < F; i++) begin : g_div
    fatan_div_stage #(.NW(NW), .QW(F), .BIT(F - 1 - i)) u_stage (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(v[i]), .in_flags(fl[i]), .in_rem(rem[i]), .in_d2(d2[i]), .in_q(q[i]),
      .out_valid(v[i+1]), .out_flags(fl[i+1]), .out_rem(rem[i+1]),
      .out_d2(d2[i+1]), .out_q(q[i+1])
    );
  end

  fatan_back #(.ANGLE_FRAC_BITS(F), .AWD(AWD), .PI_S(PI_S), .HALF_PI_S(HALF_PI_S)) u_back (
    .clk(clk), .rst(rst), .en(en), .in_valid(v[F]), .in_flags(fl[F]), .in_q(q[F]),
    .out_valid(out_valid), .angle(angle)
  );

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(angle) <= $signed(PI_S) && $signed(angle) >= -$signed(PI_S)))
    else $error("angle outside clamp range");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v[F]) && $stable(q[F]))
    else $error("pipeline moved during stall");

  a_axis: assert property (@(posedge clk) disable iff (rst)
    v[F] && fl[F].x_zero && fl[F].y_zero && en |=> out_valid && angle == '0)
    else $error("origin must give zero angle");
endmodule
`default_nettype wire
